/* sv/lshe_pkg.sv */
`default_nettype none

package lshe_pkg;

    // field widths
    localparam int CHAR_W = 16;
    localparam int HASH_W = 16;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 4;

    // rotate-xor only hashes this many leading characters; count saturates here
    localparam logic [CNT_W-1:0] ROTATE_CHAR_LIMIT = CNT_W'(13);

    // hash mode codes; bit 1 selects case folding, any nonzero selects shift-add
    localparam logic [MODE_W-1:0] MODE_ROTXOR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHADD_CF = 2'd2;
    localparam int                MODE_FOLD_BIT = 1;

    localparam logic [CHAR_W-1:0] FOLD_MASK = 16'h0020;

    // one character transaction
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              first_char;
        logic              last_char;
        logic              empty_string;
    } t_char_item;

    // rotate left by 7
    function automatic logic [HASH_W-1:0] rotl7(input logic [HASH_W-1:0] v);
        return {v[8:0], v[15:9]};
    endfunction

    // h += (h & 0xfff) << 2; h += c + ((h & 0xff) << 8), all mod 2^16
    function automatic logic [HASH_W-1:0] shift_add(input logic [HASH_W-1:0] h,
                                                    input logic [CHAR_W-1:0] c);
        logic [HASH_W-1:0] h1;
        h1 = h + {2'b00, h[11:0], 2'b00};
        return h1 + c + {h1[7:0], 8'h00};
    endfunction

endpackage

`default_nettype wire

/* sv/lshe_in_stage.sv */
`default_nettype none

module lshe_in_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lshe_pkg::t_char_item i_item,
    input  wire logic                i_advance,
    output logic                     o_valid,
    output lshe_pkg::t_char_item     o_item
);

    logic                 r_valid;
    logic                 n_valid;
    lshe_pkg::t_char_item r_item;
    logic                 w_accept;

    // stall upstream only while a held item cannot move on
    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // occupancy of the input register
    always_comb begin
        priority if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* sv/lshe_hash_core.sv */
`default_nettype none

module lshe_hash_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire lshe_pkg::t_char_item          i_item,
    input  wire logic [lshe_pkg::MODE_W-1:0]   i_mode,
    output logic                               o_advance,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lshe_pkg::HASH_W-1:0]        o_hash_value
);

    logic [lshe_pkg::HASH_W-1:0] r_hash;
    logic [lshe_pkg::HASH_W-1:0] n_hash;
    logic [lshe_pkg::CNT_W-1:0]  r_cnt;
    logic [lshe_pkg::CNT_W-1:0]  n_cnt;
    logic                        r_out_valid;
    logic [lshe_pkg::HASH_W-1:0] r_out_hash;

    logic [lshe_pkg::HASH_W-1:0] w_hash_base;
    logic [lshe_pkg::CNT_W-1:0]  w_cnt_base;
    logic [lshe_pkg::HASH_W-1:0] w_hash_step;
    logic [lshe_pkg::CHAR_W-1:0] w_char;
    logic                        w_below_limit;
    logic                        w_emit;
    logic [lshe_pkg::HASH_W-1:0] w_result;

    // item moves on when the result register is free or being drained
    assign o_advance = i_valid && (!r_out_valid || !i_out_stall);

    // start of string restarts from zero
    assign w_hash_base   = i_item.first_char ? '0 : r_hash;
    assign w_cnt_base    = i_item.first_char ? '0 : r_cnt;
    assign w_below_limit = (w_cnt_base < lshe_pkg::ROTATE_CHAR_LIMIT);

    // character folding for mode with bit 1 set
    assign w_char = i_mode[lshe_pkg::MODE_FOLD_BIT]
                  ? (i_item.char_code | lshe_pkg::FOLD_MASK) : i_item.char_code;

    // one hash step in the current mode
    always_comb begin
        if (i_mode == lshe_pkg::MODE_ROTXOR) begin
            w_hash_step = w_below_limit
                        ? lshe_pkg::rotl7(w_hash_base ^ i_item.char_code) : w_hash_base;
        end else begin
            w_hash_step = lshe_pkg::shift_add(w_hash_base, w_char);
        end
    end

    assign w_emit   = i_item.empty_string || i_item.last_char;
    assign w_result = i_item.empty_string ? '0 : w_hash_step;

    // next running state; cleared at every string end
    always_comb begin
        n_hash = r_hash;
        n_cnt  = r_cnt;
        if (o_advance) begin
            if (w_emit) begin
                n_hash = '0;
                n_cnt  = '0;
            end else begin
                n_hash = w_hash_step;
                n_cnt  = w_below_limit ? (w_cnt_base + 1'b1) : w_cnt_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_cnt  <= '0;
        end else begin
            r_hash <= n_hash;
            r_cnt  <= n_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && w_emit) begin
            r_out_hash <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

`default_nettype wire

/* sv/lisp_string_hash_engine.sv */
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_char_code, i_first_char, i_last_char,
//                                                i_empty_string
// out       output     o_out_valid / i_out_stall o_hash_value
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_hash_mode
//
// one character per cycle while the result is not stalled; a hash passes through the
// input register, then the result register behind the hash step logic
// synchronous active-low reset clears the running hash, count and result valid,
// and sets hash_mode to shift-add
// a stalled result holds the hash step, so the input register fills and the input stalls
// configuration is always ready; writes belong where no transaction is in flight
`default_nettype none

module lisp_string_hash_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [lshe_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                        i_first_char,
    input  wire logic                        i_last_char,
    input  wire logic                        i_empty_string,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [lshe_pkg::HASH_W-1:0]      o_hash_value,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lshe_pkg::MODE_W-1:0] i_cfg_hash_mode
);

    logic [lshe_pkg::MODE_W-1:0] r_mode;
    lshe_pkg::t_char_item        w_in_item;
    lshe_pkg::t_char_item        w_held_item;
    logic                        w_held_valid;
    logic                        w_advance;

    // mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lshe_pkg::MODE_SHADD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_hash_mode;
        end
    end

    assign w_in_item.char_code    = i_char_code;
    assign w_in_item.first_char   = i_first_char;
    assign w_in_item.last_char    = i_last_char;
    assign w_in_item.empty_string = i_empty_string;

    // input register
    lshe_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (w_in_item),
        .i_advance  (w_advance),
        .o_valid    (w_held_valid),
        .o_item     (w_held_item)
    );

    // hash step, running state and result register
    lshe_hash_core u_hash_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_held_valid),
        .i_item       (w_held_item),
        .i_mode       (r_mode),
        .o_advance    (w_advance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

`ifndef SYNTH
    // input stalls only behind a held character
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_held_valid)
        else $error("input stalled with empty input register");

    // hash step only consumes a held character
    a_advance_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> w_held_valid)
        else $error("hash step advanced without a character");

    // empty string into an idle engine yields a zero hash through the input and result registers
    a_empty_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_empty_string && !w_held_valid && !o_out_valid)
        |=> ##1 (o_out_valid && (o_hash_value == '0)))
        else $error("empty string did not produce a zero hash");
`endif

endmodule

`default_nettype wire
